// ----- hdl/mrlb_pkg.sv -----
// ---------------------------------------------------------------------------
// mrlb_pkg
// Shared constants and the sequencer state type of the line breaker.
// ---------------------------------------------------------------------------
`default_nettype none

package mrlb_pkg;

    // default sizing
    localparam int MAX_WORDS_DEF  = 64;
    localparam int COST_WIDTH_DEF = 28;

    // fixed field widths
    localparam int LEN_W   = 8;
    localparam int WIDTH_W = 10;
    localparam int BRK_W   = 7;
    localparam int SQ_W    = 2 * WIDTH_W;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 10'd80;

    typedef enum logic [3:0] {
        S_LOAD,
        S_LAST,
        S_PJ,
        S_PJW,
        S_MID,
        S_FIRST,
        S_EMIT,
        S_CRD,
        S_CLAT
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/mrlb_line_cost.sv -----
// ---------------------------------------------------------------------------
// mrlb_line_cost
// Registered cost of one line: squared slack, zero when empty, infinity on
// overflow or on a reversed line. Carries the candidate tag and addend along.
// ---------------------------------------------------------------------------
`default_nettype none

module mrlb_line_cost #(
    parameter int PW = 14,
    parameter int VW = 7,
    parameter int CW = mrlb_pkg::COST_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    input  wire logic [VW-1:0]                i_v,
    input  wire logic [PW-1:0]                i_ps,
    input  wire logic [PW-1:0]                i_pe,
    input  wire logic                         i_zero,
    input  wire logic                         i_over,
    input  wire logic [mrlb_pkg::WIDTH_W-1:0] i_width,
    input  wire logic [CW-1:0]                i_addend,
    output logic                              o_vld,
    output logic [VW-1:0]                     o_v,
    output logic [CW-1:0]                     o_cost,
    output logic [CW-1:0]                     o_addend
);

    localparam logic [CW-1:0] INF = {CW{1'b1}};
    // character count wide enough for both the prefix sums and the width
    localparam int LW = (PW > mrlb_pkg::WIDTH_W) ? PW : mrlb_pkg::WIDTH_W;

    logic [LW-1:0]                     chars;
    logic [mrlb_pkg::WIDTH_W-1:0]      slack;
    logic [mrlb_pkg::SQ_W-1:0]         sq;
    logic [CW-1:0]                     n_cost;

    // characters on the line and squared slack
    always_comb begin
        chars = LW'(i_pe) - LW'(i_ps);
        slack = i_width - chars[mrlb_pkg::WIDTH_W-1:0];
        sq    = slack * slack;
        if (i_zero) begin
            n_cost = '0;
        end else if (i_over || (chars > LW'(i_width))) begin
            n_cost = INF;
        end else begin
            n_cost = CW'(sq);
        end
    end

    // clear the stage valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        o_v      <= i_v;
        o_cost   <= n_cost;
        o_addend <= i_addend;
    end

endmodule

`default_nettype wire

// ----- hdl/min_raggedness_line_breaker.sv -----
// Load: words are taken only in the load state. Compute for n words: a sweep
// for the last line, each of the n-2 middle stages (one candidate per cycle
// through the cost memories' single read port), then a sweep for the first.
// Results: first one on the next cycle, then each is read from the choice table
// once the last is taken; an infeasible run gives one per cycle while taken.
// Reset is synchronous: line width returns to 80, the word count to zero.
// ---------------------------------------------------------------------------
// min_raggedness_line_breaker
// Dynamic programme over prefix sums held in memory, with ping-pong stage
// cost memories and a choice table read back to trace the breaks.
// ---------------------------------------------------------------------------
`default_nettype none

module min_raggedness_line_breaker #(
    parameter int MAX_WORDS  = mrlb_pkg::MAX_WORDS_DEF,
    parameter int COST_WIDTH = mrlb_pkg::COST_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [mrlb_pkg::WIDTH_W-1:0] i_cfg_line_width,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [mrlb_pkg::LEN_W-1:0]   i_word_length,
    input  wire logic                         i_last_word,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [mrlb_pkg::BRK_W-1:0]        o_break_position,
    output logic                              o_infeasible,
    output logic                              o_last_break
);

    localparam int CW     = COST_WIDTH;
    localparam int VW     = $clog2(MAX_WORDS + 1);
    localparam int AW     = $clog2(MAX_WORDS);
    localparam int PW     = $clog2(MAX_WORDS * 255 + 1);
    localparam int CMPW   = PW + mrlb_pkg::WIDTH_W;
    localparam int TDEPTH = (MAX_WORDS - 1) * MAX_WORDS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam logic [CW-1:0]  INF   = {CW{1'b1}};
    localparam logic [VW-1:0]  MAXV  = VW'(MAX_WORDS);
    localparam logic [TAW-1:0] STEP  = TAW'(MAX_WORDS);
    localparam logic [TAW-1:0] BASE3 = TAW'(3 * MAX_WORDS);

    // memories
    logic [PW-1:0] prefix_mem [MAX_WORDS];
    logic [CW-1:0] cost_a_mem [MAX_WORDS];
    logic [CW-1:0] cost_b_mem [MAX_WORDS];
    logic [VW-1:0] choice_mem [TDEPTH];

    mrlb_pkg::t_state r_state, n_state;

    logic [mrlb_pkg::WIDTH_W-1:0] r_width;
    logic [VW-1:0]  r_count, r_j, r_v, r_stage, r_left, r_bidx, r_b, r_s1_v;
    logic [PW-1:0]  r_sum, r_pj;
    logic [TAW-1:0] r_tbase, r_rbase;
    logic [CW-1:0]  r_best;
    logic           r_bank, r_issuing, r_s1_vld;
    logic           r_out_vld, r_infeas, r_last;

    logic [PW-1:0]  prefix_q, sum_new;
    logic [CW-1:0]  cost_a_q, cost_b_q, cur_q;
    logic [VW-1:0]  choice_q, n_cnt;
    logic [AW-1:0]  pre_raddr, cost_raddr;
    logic [TAW-1:0] ch_raddr;

    logic           in_acc, out_acc, row_done, sweep, single_over;
    logic           lc_vld, lc_zero, lc_over;
    logic [VW-1:0]  lc_v;
    logic [PW-1:0]  lc_ps, lc_pe;
    logic [CW-1:0]  lc_add, lc_cost, lc_addend, cand, n_best_c;
    logic [CW:0]    sum_c;
    logic [VW-1:0]  n_bidx_c;

    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_vld;
    assign o_break_position = mrlb_pkg::BRK_W'(r_b);
    assign o_infeasible     = r_infeas;
    assign o_last_break     = r_last;

    assign in_acc   = i_valid && o_ready;
    assign out_acc  = r_out_vld && i_ready;
    assign sum_new  = r_sum + PW'(i_word_length);
    assign n_cnt    = (r_count < MAXV) ? r_count + 1'b1 : r_count;
    assign cur_q    = r_bank ? cost_b_q : cost_a_q;
    assign row_done = lc_vld && (lc_v == r_count);
    assign sweep    = (r_state == mrlb_pkg::S_LAST) || (r_state == mrlb_pkg::S_MID) ||
                      (r_state == mrlb_pkg::S_FIRST);
    assign single_over = CMPW'(sum_new) > CMPW'(r_width);

    // read addresses
    always_comb begin
        pre_raddr  = (r_state == mrlb_pkg::S_PJ) ? AW'(r_j - 1'b1) : AW'(r_v - 1'b1);
        cost_raddr = AW'(r_v - 1'b1);
        ch_raddr   = r_rbase + TAW'(r_b - 1'b1);
    end

    // line operands per phase
    always_comb begin
        lc_ps   = '0;
        lc_pe   = prefix_q;
        lc_zero = 1'b0;
        lc_over = 1'b0;
        lc_add  = cur_q;
        case (r_state)
            mrlb_pkg::S_LAST: begin
                lc_ps   = prefix_q;
                lc_pe   = r_sum;
                lc_zero = (r_s1_v == r_count);
                lc_add  = '0;
            end
            mrlb_pkg::S_MID: begin
                lc_ps   = r_pj;
                lc_zero = (r_s1_v == r_j);
                lc_over = (r_s1_v < r_j);
            end
            default: begin
                lc_ps = '0;
            end
        endcase
    end

    mrlb_line_cost #(
        .PW(PW),
        .VW(VW),
        .CW(CW)
    ) u_line_cost (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_s1_vld),
        .i_v      (r_s1_v),
        .i_ps     (lc_ps),
        .i_pe     (lc_pe),
        .i_zero   (lc_zero),
        .i_over   (lc_over),
        .i_width  (r_width),
        .i_addend (lc_add),
        .o_vld    (lc_vld),
        .o_v      (lc_v),
        .o_cost   (lc_cost),
        .o_addend (lc_addend)
    );

    // saturating sum and running minimum, first index wins ties
    always_comb begin
        sum_c    = {1'b0, lc_addend} + {1'b0, lc_cost};
        cand     = (sum_c >= {1'b0, INF}) ? INF : sum_c[CW-1:0];
        n_best_c = r_best;
        n_bidx_c = r_bidx;
        if (lc_vld && (cand < r_best)) begin
            n_best_c = cand;
            n_bidx_c = lc_v;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrlb_pkg::S_LOAD: begin
                if (in_acc && i_last_word) begin
                    n_state = (n_cnt == VW'(1)) ? mrlb_pkg::S_EMIT : mrlb_pkg::S_LAST;
                end
            end
            mrlb_pkg::S_LAST: begin
                if (row_done) begin
                    n_state = (r_stage == '0) ? mrlb_pkg::S_FIRST : mrlb_pkg::S_PJ;
                end
            end
            mrlb_pkg::S_PJ:  n_state = mrlb_pkg::S_PJW;
            mrlb_pkg::S_PJW: n_state = mrlb_pkg::S_MID;
            mrlb_pkg::S_MID: begin
                if (row_done) begin
                    if ((r_j == r_count) && (r_stage == VW'(1))) begin
                        n_state = mrlb_pkg::S_FIRST;
                    end else begin
                        n_state = mrlb_pkg::S_PJ;
                    end
                end
            end
            mrlb_pkg::S_FIRST: begin
                if (row_done) begin
                    n_state = mrlb_pkg::S_EMIT;
                end
            end
            mrlb_pkg::S_EMIT: begin
                if (out_acc) begin
                    if (r_left == '0) begin
                        n_state = mrlb_pkg::S_LOAD;
                    end else if (!r_infeas) begin
                        n_state = mrlb_pkg::S_CRD;
                    end
                end
            end
            mrlb_pkg::S_CRD:  n_state = mrlb_pkg::S_CLAT;
            mrlb_pkg::S_CLAT: n_state = mrlb_pkg::S_EMIT;
            default:          n_state = mrlb_pkg::S_LOAD;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = (r_state == mrlb_pkg::S_LOAD);
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < MAXV)) begin
            prefix_mem[AW'(r_count)] <= sum_new;
        end
        prefix_q <= prefix_mem[pre_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (((r_state == mrlb_pkg::S_LAST) && lc_vld && !r_bank) ||
            ((r_state == mrlb_pkg::S_MID) && row_done && r_bank)) begin
            cost_a_mem[(r_state == mrlb_pkg::S_LAST) ? AW'(lc_v - 1'b1) : AW'(r_j - 1'b1)]
                <= (r_state == mrlb_pkg::S_LAST) ? cand : n_best_c;
        end
        cost_a_q <= cost_a_mem[cost_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (((r_state == mrlb_pkg::S_LAST) && lc_vld && r_bank) ||
            ((r_state == mrlb_pkg::S_MID) && row_done && !r_bank)) begin
            cost_b_mem[(r_state == mrlb_pkg::S_LAST) ? AW'(lc_v - 1'b1) : AW'(r_j - 1'b1)]
                <= (r_state == mrlb_pkg::S_LAST) ? cand : n_best_c;
        end
        cost_b_q <= cost_b_mem[cost_raddr];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mrlb_pkg::S_MID) && row_done) begin
            choice_mem[r_tbase + TAW'(r_j - 1'b1)] <= n_bidx_c;
        end
        choice_q <= choice_mem[ch_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrlb_pkg::S_LOAD;
            r_width   <= mrlb_pkg::LINE_WIDTH_RST;
            r_count   <= '0;
            r_sum     <= '0;
            r_issuing <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_bank    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_width <= i_cfg_line_width;
            end

            // issue one candidate read per cycle during a sweep
            r_s1_vld <= sweep && r_issuing;
            if (sweep && r_issuing) begin
                r_v <= r_v + 1'b1;
                if (r_v == r_count) begin
                    r_issuing <= 1'b0;
                end
            end

            case (r_state)
                mrlb_pkg::S_LOAD: begin
                    if (in_acc) begin
                        if (r_count < MAXV) begin
                            r_sum   <= sum_new;
                            r_count <= r_count + 1'b1;
                        end
                        if (i_last_word) begin
                            if (n_cnt == VW'(1)) begin
                                r_out_vld <= 1'b1;
                                r_infeas  <= single_over;
                                r_b       <= single_over ? '0 : VW'(1);
                                r_last    <= 1'b1;
                                r_left    <= '0;
                            end else begin
                                r_issuing <= 1'b1;
                                r_v       <= VW'(1);
                                r_stage   <= n_cnt - VW'(2);
                                r_tbase   <= TAW'(n_cnt) * STEP - BASE3;
                            end
                        end
                    end
                end
                mrlb_pkg::S_LAST: begin
                    if (row_done) begin
                        r_j       <= VW'(1);
                        r_issuing <= (r_stage == '0);
                        r_v       <= VW'(1);
                        r_best    <= INF;
                        r_bidx    <= '0;
                    end
                end
                mrlb_pkg::S_PJW: begin
                    r_pj      <= prefix_q;
                    r_issuing <= 1'b1;
                    r_v       <= VW'(1);
                    r_best    <= INF;
                    r_bidx    <= '0;
                end
                mrlb_pkg::S_MID: begin
                    if (row_done && (r_j == r_count)) begin
                        r_bank    <= ~r_bank;
                        r_stage   <= r_stage - 1'b1;
                        r_tbase   <= r_tbase - STEP;
                        r_j       <= VW'(1);
                        r_issuing <= (r_stage == VW'(1));
                        r_v       <= VW'(1);
                        r_best    <= INF;
                        r_bidx    <= '0;
                    end else begin
                        r_best <= n_best_c;
                        r_bidx <= n_bidx_c;
                        if (row_done) begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                mrlb_pkg::S_FIRST: begin
                    r_best <= n_best_c;
                    r_bidx <= n_bidx_c;
                    if (row_done) begin
                        r_out_vld <= 1'b1;
                        r_infeas  <= (n_best_c == INF);
                        r_b       <= (n_best_c == INF) ? '0 : n_bidx_c;
                        r_last    <= (r_count == VW'(2));
                        r_left    <= r_count - VW'(2);
                        r_rbase   <= '0;
                    end
                end
                mrlb_pkg::S_EMIT: begin
                    if (out_acc) begin
                        if (r_left == '0) begin
                            r_out_vld <= 1'b0;
                            r_count   <= '0;
                            r_sum     <= '0;
                        end else if (r_infeas) begin
                            r_last <= (r_left == VW'(1));
                            r_left <= r_left - 1'b1;
                        end else begin
                            r_out_vld <= 1'b0;
                        end
                    end
                end
                mrlb_pkg::S_CLAT: begin
                    r_b       <= choice_q;
                    r_out_vld <= 1'b1;
                    r_last    <= (r_left == VW'(1));
                    r_left    <= r_left - 1'b1;
                    r_rbase   <= r_rbase + STEP;
                end
                default: begin
                end
            endcase

            r_s1_v <= r_v;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_min_raggedness_line_breaker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_min_raggedness_line_breaker
// Drives paragraphs of word lengths into the line breaker, predicts every
// break with a local dynamic programme and compares each result transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_min_raggedness_line_breaker;

    localparam int NW      = mrlb_pkg::MAX_WORDS_DEF;
    localparam int CW      = mrlb_pkg::COST_WIDTH_DEF;
    localparam longint INF = (longint'(1) << CW) - 1;
    localparam int WD_LIM  = 400000;

    typedef struct packed {
        logic [mrlb_pkg::LEN_W-1:0] len;
        logic                       last;
    } t_word;

    typedef struct packed {
        logic [mrlb_pkg::BRK_W-1:0] pos;
        logic                       infeas;
        logic                       lastb;
    } t_brk;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [mrlb_pkg::WIDTH_W-1:0] i_cfg_line_width = '0;
    logic i_valid = 0;
    logic o_ready;
    logic [mrlb_pkg::LEN_W-1:0] i_word_length = '0;
    logic i_last_word = 0;
    logic o_valid;
    logic i_ready = 0;
    logic [mrlb_pkg::BRK_W-1:0] o_break_position;
    logic o_infeasible;
    logic o_last_break;

    min_raggedness_line_breaker dut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_line_width,
        .i_valid, .o_ready, .i_word_length, .i_last_word,
        .o_valid, .i_ready, .o_break_position, .o_infeasible, .o_last_break
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    int    pm_width = 80;
    int    pm_prefix[NW+1];
    int    pm_count = 0;
    t_word word_q[$];
    t_brk  brk_q[$];
    int    errors = 0;
    int    words_done = 0;
    int    hold_off = 0;
    int    idle_cycles = 0;

    function automatic longint seg_cost(int s, int e);
        int chars;
        longint sl;
        if (s == e) return 0;
        if (s > e) return INF;
        chars = pm_prefix[e] - pm_prefix[s];
        if (chars > pm_width) return INF;
        sl = pm_width - chars;
        return (sl * sl > INF) ? INF : sl * sl;
    endfunction

    function automatic longint sadd(longint a, longint b);
        return (a + b > INF) ? INF : a + b;
    endfunction

    task automatic push_infeasible(int cnt);
        t_brk r;
        for (int q = 0; q < cnt; q++) begin
            r.pos = 0; r.infeas = 1; r.lastb = (q == cnt - 1);
            brk_q.push_back(r);
        end
    endtask

    // solve the paragraph held and queue its breaks
    task automatic predict_breaks();
        int n;
        longint cur[NW], nxt[NW], best, cand;
        int choice[NW][NW];
        int path[NW];
        int b, bj;
        t_brk r;
        n = pm_count;
        if (n <= 1) begin
            if (seg_cost(0, n) >= INF) push_infeasible(1);
            else begin
                r.pos = 1; r.infeas = 0; r.lastb = 1;
                brk_q.push_back(r);
            end
            return;
        end
        for (int k = 1; k <= n; k++) cur[k-1] = seg_cost(k, n);
        for (int i = n - 2; i >= 1; i--) begin
            for (int j = 1; j <= n; j++) begin
                best = INF; b = 0;
                for (int k = 1; k <= n; k++) begin
                    cand = sadd(cur[k-1], seg_cost(j, k));
                    if (cand < best) begin
                        best = cand; b = k;
                    end
                end
                nxt[j-1] = best;
                choice[i-1][j-1] = b;
            end
            cur = nxt;
        end
        best = INF; bj = 0;
        for (int j = 1; j <= n; j++) begin
            cand = sadd(seg_cost(0, j), cur[j-1]);
            if (cand < best) begin
                best = cand; bj = j;
            end
        end
        if (best >= INF || bj == 0) begin
            push_infeasible(n - 1);
            return;
        end
        // trace the whole path first; a broken path makes the run infeasible
        b = bj;
        for (int i = 0; i + 1 < n; i++) begin
            if (i > 0) begin
                b = choice[i-1][b-1];
                if (b == 0 || b > n) begin
                    push_infeasible(n - 1);
                    return;
                end
            end
            path[i] = b;
        end
        for (int i = 0; i + 1 < n; i++) begin
            r.pos = mrlb_pkg::BRK_W'(path[i]); r.infeas = 0; r.lastb = (i + 2 == n);
            brk_q.push_back(r);
        end
    endtask

    task automatic take_word(t_word w);
        if (pm_count < NW) begin
            if (pm_count == 0) pm_prefix[0] = 0;
            pm_prefix[pm_count+1] = pm_prefix[pm_count] + w.len;
            pm_count++;
        end
        if (w.last) begin
            predict_breaks();
            pm_count = 0;
        end
    endtask

    // queue a paragraph of n words, lengths drawn in [lo, hi]
    task automatic add_para(int n, int lo, int hi);
        t_word w;
        for (int q = 0; q < n; q++) begin
            w.len = mrlb_pkg::LEN_W'($urandom_range(hi, lo));
            w.last = (q == n - 1);
            word_q.push_back(w);
        end
    endtask

    // driver: hold each word until accepted, random gap before the next
    int gap = 0;
    logic driving = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                take_word({i_word_length, i_last_word});
                words_done <= words_done + 1;
            end
            if (!(i_valid && !o_ready)) begin
                if (driving && gap > 0) begin
                    gap <= gap - 1;
                    i_valid <= 0;
                end else if (driving && word_q.size() > 0) begin
                    t_word w;
                    w = word_q.pop_front();
                    i_word_length <= w.len;
                    i_last_word <= w.last;
                    i_valid <= 1;
                    gap <= $urandom_range(4, 0);
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // monitor: check each result, random stall per result, long hold-off on demand
    int stall = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_brk e;
                if (brk_q.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d inf=%0b last=%0b", $time,
                             o_break_position, o_infeasible, o_last_break);
                    errors++;
                end else begin
                    e = brk_q.pop_front();
                    if (e.pos != o_break_position)
                        $display("%0t: break_position exp %0d got %0d", $time,
                                 e.pos, o_break_position);
                    if (e.infeas != o_infeasible)
                        $display("%0t: infeasible exp %0b got %0b", $time,
                                 e.infeas, o_infeasible);
                    if (e.lastb != o_last_break)
                        $display("%0t: last_break exp %0b got %0b", $time,
                                 e.lastb, o_last_break);
                    if (e != {o_break_position, o_infeasible, o_last_break}) errors++;
                end
                stall = $urandom_range(4, 0);
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready <= 0;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
            // watchdog over cycles with no transaction
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready)
                || hold_off > 0)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIM) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (word_q.size() > 0 || i_valid || brk_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_width(int wv);
        i_cfg_line_width <= mrlb_pkg::WIDTH_W'(wv);
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        pm_width = wv;
    endtask

    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        driving <= 1;
        // directed: reset width, single word fits and overflows, extremes
        add_para(1, 80, 80);
        add_para(1, 81, 81);
        add_para(3, 1, 1);
        add_para(3, 255, 255);
        add_para(4, 20, 60);
        add_para(6, 1, 255);
        wait_drained();
        // narrowest width: a one-word run that fits, then a run of short words
        set_width(1);
        add_para(1, 1, 1);
        add_para(3, 1, 2);
        wait_drained();
        // widest width, full and overfull paragraph
        set_width(1023);
        add_para(2, 255, 255);
        add_para(66, 1, 255);
        wait_drained();
        // long hold-off while words keep coming
        set_width(100);
        hold_off <= 400;
        add_para(5, 10, 40);
        add_para(5, 10, 40);
        add_para(5, 10, 40);
        wait_drained();
        // random phases over several widths
        for (int ph = 0; ph < 6; ph++) begin
            set_width((ph == 5) ? 1023 : $urandom_range(300, 1));
            while (words_done < 130 + ph * 65 && word_q.size() < 200) begin
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 20)
                                                : $urandom_range(10, 1);
                add_para(n, 1, ($urandom_range(1, 0) ? 255 : pm_width / 3 + 1));
                while (word_q.size() > 20) @(posedge i_clk);
            end
            wait_drained();
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
hdl/mrlb_pkg.sv
hdl/mrlb_line_cost.sv
hdl/min_raggedness_line_breaker.sv
test/tb_min_raggedness_line_breaker.sv
